// ----- design/les_pkg.sv -----
// shared types and constants of the lorenz euler step unit
`timescale 1ns / 1ps
package les_pkg;

  // program counter of the control store
  localparam int unsigned PC_W = 4;

  // fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW  = 3'd4;

  // configuration reset values
  localparam logic [31:0] SIGMA_RST = 32'd167772160;
  localparam logic [31:0] BETA_RST  = 32'd44738123;
  localparam logic [31:0] RHO_RST   = 32'd469762048;
  localparam logic [30:0] DT_RST    = 31'd16777;
  localparam logic [31:0] VIEW_RST  = 32'd419430;

  // sequencer branch kinds
  typedef enum logic [1:0] {
    BR_NEXT     = 2'd0,
    BR_WAIT_IN  = 2'd1,
    BR_WAIT_OUT = 2'd2,
    BR_JUMP     = 2'd3
  } branch_e;

  // multiplier operand a
  typedef enum logic [2:0] {
    MA_SIGMA = 3'd0,
    MA_BETA  = 3'd1,
    MA_X     = 3'd2,
    MA_DT    = 3'd3,
    MA_VIEW  = 3'd4
  } mul_a_e;

  // multiplier operand b
  typedef enum logic [2:0] {
    MB_T  = 3'd0,
    MB_X  = 3'd1,
    MB_Y  = 3'd2,
    MB_Z  = 3'd3,
    MB_DX = 3'd4,
    MB_DY = 3'd5,
    MB_DZ = 3'd6
  } mul_b_e;

  // adder operand a
  typedef enum logic [2:0] {
    AA_PROD = 3'd0,
    AA_ACC  = 3'd1,
    AA_X    = 3'd2,
    AA_Y    = 3'd3,
    AA_Z    = 3'd4,
    AA_RHO  = 3'd5
  } add_a_e;

  // adder operand b
  typedef enum logic [2:0] {
    AB_ZERO     = 3'd0,
    AB_PROD     = 3'd1,
    AB_NEG_PROD = 3'd2,
    AB_NEG_X    = 3'd3,
    AB_NEG_Y    = 3'd4,
    AB_NEG_Z    = 3'd5
  } add_b_e;

  // adder result destination
  typedef enum logic [3:0] {
    DST_NONE = 4'd0,
    DST_T    = 4'd1,
    DST_ACC  = 4'd2,
    DST_DX   = 4'd3,
    DST_DY   = 4'd4,
    DST_DZ   = 4'd5,
    DST_X    = 4'd6,
    DST_Y    = 4'd7,
    DST_Z    = 4'd8,
    DST_PX   = 4'd9,
    DST_PY   = 4'd10,
    DST_OUT  = 4'd11
  } dst_e;

  // one control word
  typedef struct packed {
    branch_e         br;
    logic [PC_W-1:0] tgt;
    logic            mul_en;
    mul_a_e          mul_a;
    mul_b_e          mul_b;
    add_a_e          add_a;
    add_b_e          add_b;
    dst_e            dst;
  } ctrl_t;

endpackage

// ----- design/lorenz_euler_step_unit.sv -----
// top level of the lorenz euler step unit
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i[2:0], cfg_data_i[31:0]
//  in      | in        | in_valid_i/in_ready_o   | restart_i
//  out     | out       | out_valid_o/out_ready_i | point_x/y/z_o[31:0], saturated_o
//
//  one step: a wait-for-input word that takes the beat, then
//  12 words that run ten products through one shared 32x32 multiplier and one
//  saturating adder, word after word; the last word loads the output register
//  reset puts the program counter on its wait-for-input word, loads the
//  default coefficients and sets x, y and z to 1.0; no clearing pass
//  the result sits in an output register, so a new input beat is taken while
//  it waits; the last program word holds until that register is free
//  cfg_ready_o is always high; write only while idle
`timescale 1ns / 1ps
module lorenz_euler_step_unit #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [les_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [les_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   point_x_o,
  output logic [31:0]                   point_y_o,
  output logic [31:0]                   point_z_o,
  output logic                          saturated_o
);

  logic [les_pkg::PC_W-1:0] pc;
  les_pkg::ctrl_t           ctrl;
  logic                     fire;
  logic                     accept;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  les_ucode_rom u_rom (
    .pc_i   (pc),
    .ctrl_o (ctrl)
  );

  les_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .pc_o        (pc),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .fire_o      (fire)
  );

  // accept beat reloads state on restart and clears the clip flag
  les_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .fire_i      (fire),
    .accept_i    (accept),
    .restart_i   (restart_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .saturated_o (saturated_o)
  );

endmodule

// ----- design/les_ucode_rom.sv -----
// control store holding the euler step program
`timescale 1ns / 1ps
module les_ucode_rom (
  input  logic [les_pkg::PC_W-1:0] pc_i,
  output les_pkg::ctrl_t           ctrl_o
);

  // product of the mul issued in step k is consumed by the adder in step k+1
  always_comb begin
    ctrl_o = '{br: les_pkg::BR_NEXT, tgt: '0, mul_en: 1'b0,
               mul_a: les_pkg::MA_SIGMA, mul_b: les_pkg::MB_T,
               add_a: les_pkg::AA_PROD, add_b: les_pkg::AB_ZERO,
               dst: les_pkg::DST_NONE};
    unique case (pc_i)
      4'd0: begin
        ctrl_o.br = les_pkg::BR_WAIT_IN;
      end
      4'd1: begin
        // t = y - x
        ctrl_o.add_a = les_pkg::AA_Y;
        ctrl_o.add_b = les_pkg::AB_NEG_X;
        ctrl_o.dst   = les_pkg::DST_T;
      end
      4'd2: begin
        // sigma * t, then t = rho - z
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_SIGMA;
        ctrl_o.mul_b  = les_pkg::MB_T;
        ctrl_o.add_a  = les_pkg::AA_RHO;
        ctrl_o.add_b  = les_pkg::AB_NEG_Z;
        ctrl_o.dst    = les_pkg::DST_T;
      end
      4'd3: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_X;
        ctrl_o.mul_b  = les_pkg::MB_T;
        ctrl_o.dst    = les_pkg::DST_DX;
      end
      4'd4: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_X;
        ctrl_o.mul_b  = les_pkg::MB_Y;
        ctrl_o.add_b  = les_pkg::AB_NEG_Y;
        ctrl_o.dst    = les_pkg::DST_DY;
      end
      4'd5: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_BETA;
        ctrl_o.mul_b  = les_pkg::MB_Z;
        ctrl_o.dst    = les_pkg::DST_ACC;
      end
      4'd6: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_DT;
        ctrl_o.mul_b  = les_pkg::MB_DX;
        ctrl_o.add_a  = les_pkg::AA_ACC;
        ctrl_o.add_b  = les_pkg::AB_NEG_PROD;
        ctrl_o.dst    = les_pkg::DST_DZ;
      end
      4'd7: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_DT;
        ctrl_o.mul_b  = les_pkg::MB_DY;
        ctrl_o.add_a  = les_pkg::AA_X;
        ctrl_o.add_b  = les_pkg::AB_PROD;
        ctrl_o.dst    = les_pkg::DST_X;
      end
      4'd8: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_DT;
        ctrl_o.mul_b  = les_pkg::MB_DZ;
        ctrl_o.add_a  = les_pkg::AA_Y;
        ctrl_o.add_b  = les_pkg::AB_PROD;
        ctrl_o.dst    = les_pkg::DST_Y;
      end
      4'd9: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_VIEW;
        ctrl_o.mul_b  = les_pkg::MB_X;
        ctrl_o.add_a  = les_pkg::AA_Z;
        ctrl_o.add_b  = les_pkg::AB_PROD;
        ctrl_o.dst    = les_pkg::DST_Z;
      end
      4'd10: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_VIEW;
        ctrl_o.mul_b  = les_pkg::MB_Y;
        ctrl_o.dst    = les_pkg::DST_PX;
      end
      4'd11: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_a  = les_pkg::MA_VIEW;
        ctrl_o.mul_b  = les_pkg::MB_Z;
        ctrl_o.dst    = les_pkg::DST_PY;
      end
      4'd12: begin
        ctrl_o.br  = les_pkg::BR_WAIT_OUT;
        ctrl_o.tgt = '0;
        ctrl_o.dst = les_pkg::DST_OUT;
      end
      default: begin
        ctrl_o.br  = les_pkg::BR_JUMP;
        ctrl_o.tgt = '0;
      end
    endcase
  end

endmodule

// ----- design/les_sequencer.sv -----
// step counter with conditional branches and the result valid flag
`timescale 1ns / 1ps
module les_sequencer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  les_pkg::ctrl_t           ctrl_i,
  input  logic                     in_valid_i,
  input  logic                     out_ready_i,
  output logic [les_pkg::PC_W-1:0] pc_o,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output logic                     fire_o
);

  logic [les_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     out_valid_q, out_valid_d;
  logic                     slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (ctrl_i.br)
      les_pkg::BR_WAIT_IN:  fire_o = in_valid_i;
      les_pkg::BR_WAIT_OUT: fire_o = slot_free;
      default:              fire_o = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (fire_o) begin
      unique case (ctrl_i.br)
        les_pkg::BR_WAIT_OUT, les_pkg::BR_JUMP: pc_d = ctrl_i.tgt;
        default:                                pc_d = pc_q + 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire_o && ctrl_i.br == les_pkg::BR_WAIT_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign pc_o        = pc_q;
  assign in_ready_o  = ctrl_i.br == les_pkg::BR_WAIT_IN;
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/les_datapath.sv -----
// shared multiplier, saturating adder, state and configuration registers
`timescale 1ns / 1ps
module les_datapath #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [les_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [les_pkg::DATA_W-1:0]    cfg_data_i,
  input  les_pkg::ctrl_t                ctrl_i,
  input  logic                          fire_i,
  input  logic                          accept_i,
  input  logic                          restart_i,
  output logic [31:0]                   point_x_o,
  output logic [31:0]                   point_y_o,
  output logic [31:0]                   point_z_o,
  output logic                          saturated_o
);

  // 1.0, clipped when it does not fit in 32 signed bits
  localparam logic [31:0] ONE =
    (FRAC_BITS >= 31) ? 32'h7FFF_FFFF : 32'(64'd1 << FRAC_BITS);

  logic [31:0] sigma_q, beta_q, rho_q, view_q;
  logic [30:0] dt_q;
  logic [31:0] x_q, y_q, z_q;
  logic [31:0] t_q, dx_q, dy_q, dz_q, px_q, py_q;
  logic [63:0] acc_q;
  logic signed [63:0] prod_q;
  logic        clip_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;
  logic        out_sat_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] mul_p, shp;
  logic signed [65:0] opa, opb, sum;
  logic [32:0]        sat_r;
  logic               wr_sat;

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v[65:31] != {35{v[65]}}) begin
      r = {1'b1, v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  always_comb begin
    unique case (ctrl_i.mul_a)
      les_pkg::MA_SIGMA: ma = sigma_q;
      les_pkg::MA_BETA:  ma = beta_q;
      les_pkg::MA_X:     ma = x_q;
      les_pkg::MA_DT:    ma = {1'b0, dt_q};
      les_pkg::MA_VIEW:  ma = view_q;
      default:           ma = '0;
    endcase
    unique case (ctrl_i.mul_b)
      les_pkg::MB_T:  mb = t_q;
      les_pkg::MB_X:  mb = x_q;
      les_pkg::MB_Y:  mb = y_q;
      les_pkg::MB_Z:  mb = z_q;
      les_pkg::MB_DX: mb = dx_q;
      les_pkg::MB_DY: mb = dy_q;
      les_pkg::MB_DZ: mb = dz_q;
      default:        mb = '0;
    endcase
  end

  assign mul_p = ma * mb;
  // floor truncation of the registered product
  assign shp   = prod_q >>> FRAC_BITS;

  always_comb begin
    unique case (ctrl_i.add_a)
      les_pkg::AA_PROD: opa = {{2{shp[63]}}, shp};
      les_pkg::AA_ACC:  opa = {{2{acc_q[63]}}, acc_q};
      les_pkg::AA_X:    opa = {{34{x_q[31]}}, x_q};
      les_pkg::AA_Y:    opa = {{34{y_q[31]}}, y_q};
      les_pkg::AA_Z:    opa = {{34{z_q[31]}}, z_q};
      les_pkg::AA_RHO:  opa = {{34{rho_q[31]}}, rho_q};
      default:          opa = '0;
    endcase
    unique case (ctrl_i.add_b)
      les_pkg::AB_ZERO:     opb = '0;
      les_pkg::AB_PROD:     opb = {{2{shp[63]}}, shp};
      les_pkg::AB_NEG_PROD: opb = -{{2{shp[63]}}, shp};
      les_pkg::AB_NEG_X:    opb = -{{34{x_q[31]}}, x_q};
      les_pkg::AB_NEG_Y:    opb = -{{34{y_q[31]}}, y_q};
      les_pkg::AB_NEG_Z:    opb = -{{34{z_q[31]}}, z_q};
      default:              opb = '0;
    endcase
  end

  assign sum    = opa + opb;
  assign sat_r  = sat32(sum);
  assign wr_sat = fire_i && ctrl_i.dst != les_pkg::DST_NONE
               && ctrl_i.dst != les_pkg::DST_ACC;

  // configuration and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= les_pkg::SIGMA_RST;
      beta_q  <= les_pkg::BETA_RST;
      rho_q   <= les_pkg::RHO_RST;
      dt_q    <= les_pkg::DT_RST;
      view_q  <= les_pkg::VIEW_RST;
      x_q     <= ONE;
      y_q     <= ONE;
      z_q     <= ONE;
      clip_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          les_pkg::CFG_SIGMA: sigma_q <= cfg_data_i;
          les_pkg::CFG_BETA:  beta_q  <= cfg_data_i;
          les_pkg::CFG_RHO:   rho_q   <= cfg_data_i;
          les_pkg::CFG_DT:    dt_q    <= cfg_data_i[30:0];
          les_pkg::CFG_VIEW:  view_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        clip_q <= 1'b0;
        if (restart_i) begin
          x_q <= ONE;
          y_q <= ONE;
          z_q <= ONE;
        end
      end else if (wr_sat) begin
        clip_q <= clip_q | sat_r[32];
        case (ctrl_i.dst)
          les_pkg::DST_X: x_q <= sat_r[31:0];
          les_pkg::DST_Y: y_q <= sat_r[31:0];
          les_pkg::DST_Z: z_q <= sat_r[31:0];
          default: ;
        endcase
      end
    end
  end

  // scratch and output registers
  always_ff @(posedge clk_i) begin
    if (fire_i && ctrl_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (fire_i) begin
      case (ctrl_i.dst)
        les_pkg::DST_T:   t_q   <= sat_r[31:0];
        les_pkg::DST_ACC: acc_q <= sum[63:0];
        les_pkg::DST_DX:  dx_q  <= sat_r[31:0];
        les_pkg::DST_DY:  dy_q  <= sat_r[31:0];
        les_pkg::DST_DZ:  dz_q  <= sat_r[31:0];
        les_pkg::DST_PX:  px_q  <= sat_r[31:0];
        les_pkg::DST_PY:  py_q  <= sat_r[31:0];
        les_pkg::DST_OUT: begin
          out_x_q   <= px_q;
          out_y_q   <= py_q;
          out_z_q   <= sat_r[31:0];
          out_sat_q <= clip_q | sat_r[32];
        end
        default: ;
      endcase
    end
  end

  assign point_x_o   = out_x_q;
  assign point_y_o   = out_y_q;
  assign point_z_o   = out_z_q;
  assign saturated_o = out_sat_q;

endmodule

// ----- design/les_checker.sv -----
// port checker for the lorenz euler step unit and its bind
`timescale 1ns / 1ps
module les_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] point_x_o,
  input logic [31:0] point_y_o,
  input logic [31:0] point_z_o,
  input logic        saturated_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(point_x_o) && $stable(point_y_o)
      && $stable(point_z_o) && $stable(saturated_o))
    else $error("result payload changed while stalled");

  // one step at a time: busy right after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a step is running");

  // no result can appear that early after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !$rose(out_valid_o))
    else $error("result appeared too soon after input beat");

endmodule

bind lorenz_euler_step_unit les_checker u_les_checker (.*);
